// File: hw/rtl/i2c_bitbang_master_unit_macros.svh
// Assertion macros for the I2C bit-bang master unit checker.
`ifndef I2C_BITBANG_MASTER_UNIT_MACROS_SVH
`define I2C_BITBANG_MASTER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define I2CBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("i2cbb check failed: same-cycle rule");

// Next-cycle implication, held off during reset.
`define I2CBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("i2cbb check failed: next-cycle rule");

`endif

// File: hw/rtl/i2cbb_pkg.sv
// Shared types and constants for the I2C bit-bang master unit.
package i2cbb_pkg;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  localparam logic CFG_DELAY_TICKS    = 1'b0;
  localparam logic CFG_READ_LSB_FIRST = 1'b1;

  localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;
  localparam logic [7:0]  MSB_MASK          = 8'h80;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_t;

  typedef struct packed {
    logic [15:0] delay_ticks;
    logic        read_lsb_first;
  } cfg_t;

endpackage

// File: hw/rtl/i2cbb_seq.sv
// Bus step sequencer: phase, counters, shift register and pin state.
module i2cbb_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  i2cbb_pkg::in_t  item,
  input  i2cbb_pkg::cfg_t cfg,
  output i2cbb_pkg::out_t res
);
  import i2cbb_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S_SCLH, PH_S_SDAH, PH_S_D1, PH_S_SDAL, PH_S_D2, PH_S_SCLL,
    PH_W_BIT, PH_W_SCLH, PH_W_DLY, PH_W_SCLL, PH_W_REL, PH_W_ACK,
    PH_W_SCLL2, PH_W_END,
    PH_R_SDAH, PH_R_REL, PH_R_DLY, PH_R_SCLH, PH_R_SCLL, PH_R_NAK,
    PH_R_SCLH2, PH_R_DLY2, PH_R_SCLL2, PH_R_END,
    PH_P_SDAL, PH_P_D1, PH_P_SCLH, PH_P_D2, PH_P_SDAH, PH_P_D3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        nak_r, nak_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        en_r, en_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        busy, done;

  phase_t      cur;
  logic [15:0] lim;
  logic [15:0] wait_inc;
  logic        dly_done;
  logic [3:0]  bc_inc;

  assign lim      = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;
  assign wait_inc = wait_r + 16'd1;
  assign dly_done = (wait_inc >= lim);

  always_comb begin
    cur           = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    wait_nxt      = wait_r;
    nak_nxt       = nak_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    en_nxt        = en_r;
    ack_nxt       = ack_r;
    rx_nxt        = rx_r;
    done          = 1'b0;

    if (cur == PH_IDLE) begin
      bit_count_nxt = 4'd0;
      wait_nxt      = 16'd0;
      priority case (item.req_type)
        REQ_START: begin
          cur       = PH_S_SCLH;
          shift_nxt = item.tx_byte;
        end
        REQ_WRITE: begin
          cur       = PH_W_BIT;
          shift_nxt = item.tx_byte;
        end
        REQ_READ: begin
          cur       = PH_R_SDAH;
          shift_nxt = 8'd0;
          nak_nxt   = item.last_read;
        end
        REQ_STOP: cur = PH_P_SDAL;
        default:  cur = PH_IDLE;
      endcase
    end

    bc_inc    = bit_count_nxt + 4'd1;
    phase_nxt = cur;
    busy      = (cur != PH_IDLE);

    unique case (cur)
      PH_IDLE: ;
      PH_S_SCLH: begin scl_nxt = 1'b1; phase_nxt = PH_S_SDAH; end
      PH_S_SDAH: begin sda_nxt = 1'b1; phase_nxt = PH_S_D1; end
      PH_S_D1: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_S_SDAL;
      end
      PH_S_SDAL: begin sda_nxt = 1'b0; phase_nxt = PH_S_D2; end
      PH_S_D2: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_S_SCLL;
      end
      PH_S_SCLL: begin
        scl_nxt       = 1'b0;
        bit_count_nxt = 4'd0;
        phase_nxt     = PH_W_BIT;
      end
      PH_W_BIT: begin
        sda_nxt   = (shift_nxt & MSB_MASK) != 8'd0;
        phase_nxt = PH_W_SCLH;
      end
      PH_W_SCLH: begin scl_nxt = 1'b1; phase_nxt = PH_W_DLY; end
      PH_W_DLY: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_W_SCLL;
      end
      PH_W_SCLL: begin
        scl_nxt   = 1'b0;
        shift_nxt = {shift_nxt[6:0], 1'b0};
        if (bc_inc >= 4'd8) begin
          bit_count_nxt = 4'd0;
          phase_nxt     = PH_W_REL;
        end else begin
          bit_count_nxt = bc_inc;
          phase_nxt     = PH_W_BIT;
        end
      end
      PH_W_REL: begin en_nxt = 1'b0; phase_nxt = PH_W_ACK; end
      PH_W_ACK: begin
        scl_nxt   = 1'b1;
        ack_nxt   = item.sda_level;
        phase_nxt = PH_W_SCLL2;
      end
      PH_W_SCLL2: begin scl_nxt = 1'b0; phase_nxt = PH_W_END; end
      PH_W_END: begin
        en_nxt    = 1'b1;
        sda_nxt   = 1'b0;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      PH_R_SDAH: begin sda_nxt = 1'b1; phase_nxt = PH_R_REL; end
      PH_R_REL: begin
        en_nxt        = 1'b0;
        bit_count_nxt = 4'd0;
        phase_nxt     = PH_R_DLY;
      end
      PH_R_DLY: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_R_SCLH;
      end
      PH_R_SCLH: begin
        scl_nxt = 1'b1;
        if (cfg.read_lsb_first) begin
          shift_nxt = shift_nxt | ({7'd0, item.sda_level} << bit_count_nxt[2:0]);
        end else begin
          shift_nxt = {shift_nxt[6:0], item.sda_level};
        end
        phase_nxt = PH_R_SCLL;
      end
      PH_R_SCLL: begin
        scl_nxt = 1'b0;
        if (bc_inc >= 4'd8) begin
          bit_count_nxt = 4'd0;
          phase_nxt     = PH_R_NAK;
        end else begin
          bit_count_nxt = bc_inc;
          phase_nxt     = PH_R_DLY;
        end
      end
      PH_R_NAK: begin
        en_nxt    = 1'b1;
        sda_nxt   = nak_nxt;
        phase_nxt = PH_R_SCLH2;
      end
      PH_R_SCLH2: begin scl_nxt = 1'b1; phase_nxt = PH_R_DLY2; end
      PH_R_DLY2: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_R_SCLL2;
      end
      PH_R_SCLL2: begin scl_nxt = 1'b0; phase_nxt = PH_R_END; end
      PH_R_END: begin
        sda_nxt   = 1'b0;
        rx_nxt    = shift_nxt;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      PH_P_SDAL: begin sda_nxt = 1'b0; phase_nxt = PH_P_D1; end
      PH_P_D1: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_P_SCLH;
      end
      PH_P_SCLH: begin scl_nxt = 1'b1; phase_nxt = PH_P_D2; end
      PH_P_D2: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) phase_nxt = PH_P_SDAH;
      end
      PH_P_SDAH: begin sda_nxt = 1'b1; phase_nxt = PH_P_D3; end
      PH_P_D3: begin
        wait_nxt = dly_done ? 16'd0 : wait_inc;
        if (dly_done) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        busy      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      wait_r      <= 16'd0;
      nak_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      en_r        <= 1'b1;
      ack_r       <= 1'b0;
      rx_r        <= 8'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      wait_r      <= wait_nxt;
      nak_r       <= nak_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      en_r        <= en_nxt;
      ack_r       <= ack_nxt;
      rx_r        <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_drive  = sda_nxt;
    res.sda_enable = en_nxt;
    res.busy_res   = busy;
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_seen   = ack_nxt;
  end

endmodule

// File: hw/rtl/i2c_bitbang_master_unit.sv
// Latency: a result beat is valid in the output register the cycle after its tick is taken.
// Throughput: one tick per clock while the input is not stalled; each tick runs one sequencer step.
// The input stalls while a result waits; a new tick enters in the cycle the previous one leaves.
// Reset (rst_n low, synchronous): idle, SCL and SDA high with SDA driven, counters and
// received byte cleared, delay_ticks 10, read bits LSB first, no result pending.
module i2c_bitbang_master_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cbb_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cbb_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wdata
);
  import i2cbb_pkg::*;

  cfg_t cfg_r;
  out_t out_data_r;
  out_t step_res;
  logic out_valid_r;
  logic in_take;

  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  i2cbb_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_take),
    .item    (in_data),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks    <= DELAY_TICKS_RESET;
      cfg_r.read_lsb_first <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY_TICKS:    cfg_r.delay_ticks    <= cfg_wdata;
        CFG_READ_LSB_FIRST: cfg_r.read_lsb_first <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/i2cbb_checker.sv
// Port-level checker for the I2C bit-bang master unit, with its bind.
`include "i2c_bitbang_master_unit_macros.svh"

module i2cbb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input i2cbb_pkg::out_t out_data
);
  import i2cbb_pkg::*;

  `I2CBB_ASSERT_NOW(a_done_in_busy, clk, rst_n, out_valid && out_data.done_res, out_data.busy_res)
  `I2CBB_ASSERT_NOW(a_release_in_busy, clk, rst_n, out_valid && !out_data.sda_enable, out_data.busy_res)
  `I2CBB_ASSERT_NEXT(a_take_gives_beat, clk, rst_n, in_valid && !in_stall, out_valid)
  `I2CBB_ASSERT_NEXT(a_stalled_beat_holds, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

bind i2c_bitbang_master_unit i2cbb_checker u_i2cbb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
